>>> design/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg - shared definitions for the bicubic sdf point filter
// widths, register codes, sequencer states and lane product bundle
// ----------------------------------------------------------------------------
package bsf_pkg;

    localparam int FRAC_BITS_DEF = 8;      // default fraction width
    localparam int FRAC_IN_W     = 8;      // width of the frac fields on the port
    localparam int BASIS_BITS    = 16;     // basis weights are Q16
    localparam int BASIS_W       = 18;     // signed basis width
    localparam int SAMPLE_W      = 16;     // grid sample width
    localparam int OUT_W         = 18;     // saturated result width
    localparam int PROD_W        = BASIS_W + OUT_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int CFG_W         = 17;
    localparam int NTAP          = 4;      // taps per cubic, one lane each
    localparam int COL_W         = $clog2(NTAP);

    localparam logic [COL_W-1:0] COL_LAST       = COL_W'(NTAP - 1);
    localparam logic [CFG_W-1:0] THRESHOLD_RST  = '0;
    localparam logic [CFG_W-1:0] DIST_LIMIT_RST = CFG_W'(13);

    typedef enum logic {
        CFG_WEIGHT_THRESHOLD = 1'b0,
        CFG_DISTANCE_LIMIT   = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAC,
        ST_SQUARE,
        ST_CUBE,
        ST_BASIS,
        ST_MUL,
        ST_ADD,
        ST_SUM,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] w;
        logic signed [PROD_W-1:0] d;
    } prod_t;

endpackage

>>> design/bsf_basis.sv
// ----------------------------------------------------------------------------
// bsf_basis - catmull-rom basis weight pipeline
// four-stage pipeline: fraction, square, cube, combine and scale to Q16
// ----------------------------------------------------------------------------
module bsf_basis import bsf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic [FRAC_BITS-1:0]       frac,
    output logic signed [BASIS_W-1:0]  basis [NTAP]
);

    localparam int CW = 3 * FRAC_BITS + 4;
    localparam int SH = 3 * FRAC_BITS + 1 - BASIS_BITS;

    logic [FRAC_BITS-1:0]   f_reg, f_d_reg, f_dd_reg;
    logic [2*FRAC_BITS-1:0] f2_reg, f2_d_reg;
    logic [3*FRAC_BITS-1:0] f3_reg;
    logic signed [BASIS_W-1:0] basis_reg [NTAP];
    logic signed [BASIS_W-1:0] basis_next [NTAP];

    logic signed [CW-1:0] t3, t2s, t1s2, s3;
    logic signed [CW-1:0] c [NTAP];

    always_ff @(posedge aclk) begin
        f_reg    <= frac;
        f2_reg   <= f_reg * f_reg;
        f_d_reg  <= f_reg;
        f3_reg   <= f2_reg * f_d_reg;
        f2_d_reg <= f2_reg;
        f_dd_reg <= f_d_reg;
        basis_reg <= basis_next;
    end

    // terms f^3, f^2*S, f*S^2, S^3 in Q(3F)
    assign t3   = CW'(f3_reg);
    assign t2s  = CW'(f2_d_reg) <<< FRAC_BITS;
    assign t1s2 = CW'(f_dd_reg) <<< (2 * FRAC_BITS);
    assign s3   = CW'(1) <<< (3 * FRAC_BITS);

    assign c[0] = (t2s <<< 1) - t3 - t1s2;
    assign c[1] = (t3 <<< 1) + t3 - ((t2s <<< 2) + t2s) + (s3 <<< 1);
    assign c[2] = (t2s <<< 2) + t1s2 - ((t3 <<< 1) + t3);
    assign c[3] = t3 - t2s;

    generate
        if (SH > 0) begin : g_round
            for (genvar k = 0; k < NTAP; k++) begin : g_tap
                // round half up, floor shift
                assign basis_next[k] =
                    BASIS_W'((c[k] + (CW'(1) <<< (SH - 1))) >>> SH);
            end
        end else begin : g_exact
            for (genvar k = 0; k < NTAP; k++) begin : g_tap
                assign basis_next[k] = BASIS_W'(c[k]) <<< (-SH);
            end
        end
    endgenerate

    assign basis = basis_reg;

endmodule

>>> design/bsf_lane.sv
// ----------------------------------------------------------------------------
// bsf_lane - one tap of the cubic
// multiplies one basis weight by the weight sample and the distance sample
// ----------------------------------------------------------------------------
module bsf_lane import bsf_pkg::*; (
    input  logic                      aclk,
    input  logic signed [BASIS_W-1:0] basis,
    input  logic signed [OUT_W-1:0]   samp_w,
    input  logic signed [OUT_W-1:0]   samp_d,
    output prod_t                     prod
);

    prod_t prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg.w <= basis * samp_w;
        prod_reg.d <= basis * samp_d;
    end

    assign prod = prod_reg;

endmodule

>>> design/bsf_merge.sv
// ----------------------------------------------------------------------------
// bsf_merge - lane merge
// registered pair sums, then final add, Q16 rounding and 18-bit saturation
// ----------------------------------------------------------------------------
module bsf_merge import bsf_pkg::*; (
    input  logic                     aclk,
    input  prod_t                    prod [NTAP],
    output logic signed [OUT_W-1:0]  weight,
    output logic signed [OUT_W-1:0]  distance
);

    logic signed [SUM_W-1:0] pair_w_reg [2];
    logic signed [SUM_W-1:0] pair_d_reg [2];

    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W-1:0]   tot;
        logic signed [SUM_W-1:0]   shv;
        logic [SUM_W-OUT_W:0]      hi;
        logic signed [OUT_W-1:0]   res;
        tot = a + b + (SUM_W'(1) <<< (BASIS_BITS - 1));
        shv = tot >>> BASIS_BITS;
        hi  = shv[SUM_W-1:OUT_W-1];
        if (&hi || ~|hi) begin
            res = shv[OUT_W-1:0];
        end else if (shv[SUM_W-1]) begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return res;
    endfunction

    always_ff @(posedge aclk) begin
        pair_w_reg[0] <= SUM_W'(prod[0].w) + SUM_W'(prod[1].w);
        pair_w_reg[1] <= SUM_W'(prod[2].w) + SUM_W'(prod[3].w);
        pair_d_reg[0] <= SUM_W'(prod[0].d) + SUM_W'(prod[1].d);
        pair_d_reg[1] <= SUM_W'(prod[2].d) + SUM_W'(prod[3].d);
    end

    assign weight   = round_sat(pair_w_reg[0], pair_w_reg[1]);
    assign distance = round_sat(pair_d_reg[0], pair_d_reg[1]);

endmodule

>>> design/bicubic_sdf_point_filter.sv
// ----------------------------------------------------------------------------
// bicubic_sdf_point_filter - bicubic point filter over weight and sdf grids
// catmull-rom interpolation of a 4x4 patch with threshold test
// ----------------------------------------------------------------------------
// A point arrives as four column beats (columns -1, 0, 1, 2), each carrying
// four weight and four distance samples (rows -1..2) plus frac_x and frac_y.
// Every column is reduced by a catmull-rom cubic in y at its own frac_y; after
// the fourth column a cubic in x at that beat's frac_x gives the interpolated
// weight and distance, which leave as one result beat with keep set when the
// weight is above weight_threshold and |distance| is below distance_limit.
// The first three columns produce no result beat. A column beat holds the block
// from acceptance through ST_FRAC to ST_SUM (s_tready low until ST_IDLE); the
// fourth column then reruns the datapath for the x cubic and waits in ST_OUT
// while the output register is still held by m_tready. The shared 4-stage
// basis pipeline and the four multiply lanes plus merge adder are reused for
// the y and x cubics. A finished result sits in the output register, so the
// next point's columns are accepted while it waits. Configuration writes are
// always taken and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module bicubic_sdf_point_filter import bsf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // input column beats
    input  logic             s_tvalid,
    output logic             s_tready,
    // weight_y0, weight_y1, weight_y2, weight_y3, dist_y0, dist_y1, dist_y2,
    // dist_y3, frac_x, frac_y
    input  logic [143:0]     s_tdata,
    // result beats
    output logic             m_tvalid,
    input  logic             m_tready,
    // weight_interp, dist_interp, 4 bits zero fill
    output logic [39:0]      m_tdata,
    // keep
    output logic             m_tuser,
    // register writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // sequencer
    seq_state_t state_reg, state_next;
    logic       load_in, col_wr, x_done, out_load;

    logic             phase_x_reg;          // working on the x cubic
    logic [COL_W-1:0] column_count_reg;

    // config registers
    logic [CFG_W-1:0] threshold_reg;
    logic [CFG_W-1:0] limit_reg;

    // captured column beat
    logic [SAMPLE_W-1:0]        w_reg [NTAP];
    logic signed [SAMPLE_W-1:0] d_reg [NTAP];
    logic [FRAC_IN_W-1:0]       frac_x_reg, frac_y_reg;

    // y-reduced columns
    logic signed [OUT_W-1:0] col_w_reg [NTAP];
    logic signed [OUT_W-1:0] col_d_reg [NTAP];

    // x cubic result and output register
    logic signed [OUT_W-1:0] wi_reg, di_reg;
    logic                    m_tvalid_reg;
    logic [39:0]             m_tdata_reg;
    logic                    m_tuser_reg;
    logic                    keep_next;
    logic signed [OUT_W:0]   di_ext, di_abs;

    // datapath
    logic [FRAC_BITS-1:0]      frac_sel;
    logic signed [BASIS_W-1:0] basis [NTAP];
    logic signed [OUT_W-1:0]   lane_w [NTAP];
    logic signed [OUT_W-1:0]   lane_d [NTAP];
    prod_t                     prod [NTAP];
    logic signed [OUT_W-1:0]   merge_w, merge_d;

    assign s_tready  = (state_reg == ST_IDLE);
    assign load_in   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // x stage uses frac_x of the fourth column beat
    assign frac_sel = phase_x_reg ? FRAC_BITS'(frac_x_reg) : FRAC_BITS'(frac_y_reg);

    bsf_basis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_basis (
        .aclk  (aclk),
        .frac  (frac_sel),
        .basis (basis)
    );

    // one lane per tap: samples from the beat for y, stored columns for x
    generate
        for (genvar k = 0; k < NTAP; k++) begin : g_lane
            assign lane_w[k] = phase_x_reg ? col_w_reg[k]
                                           : $signed({2'b00, w_reg[k]});
            assign lane_d[k] = phase_x_reg ? col_d_reg[k] : OUT_W'(d_reg[k]);

            bsf_lane u_lane (
                .aclk   (aclk),
                .basis  (basis[k]),
                .samp_w (lane_w[k]),
                .samp_d (lane_d[k]),
                .prod   (prod[k])
            );
        end
    endgenerate

    bsf_merge u_merge (
        .aclk     (aclk),
        .prod     (prod),
        .weight   (merge_w),
        .distance (merge_d)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and strobes; the middle states wait out the pipeline
    always_comb begin
        state_next = state_reg;
        col_wr     = 1'b0;
        x_done     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_CUBE;
            ST_CUBE:   state_next = ST_BASIS;
            ST_BASIS:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_ADD;
            ST_ADD:    state_next = ST_SUM;
            ST_SUM: begin
                if (phase_x_reg) begin
                    x_done     = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    col_wr = 1'b1;
                    if (column_count_reg == COL_LAST) begin
                        state_next = ST_FRAC;   // rerun the datapath in x
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_x_reg      <= 1'b0;
            column_count_reg <= '0;
            m_tvalid_reg     <= 1'b0;
            threshold_reg    <= THRESHOLD_RST;
            limit_reg        <= DIST_LIMIT_RST;
        end else begin
            if (col_wr) begin
                column_count_reg <= column_count_reg + 1'b1;
                if (column_count_reg == COL_LAST) begin
                    phase_x_reg <= 1'b1;
                end
            end
            if (out_load) begin
                phase_x_reg <= 1'b0;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_WEIGHT_THRESHOLD: threshold_reg <= cfg_data;
                    CFG_DISTANCE_LIMIT:   limit_reg     <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (load_in) begin
            for (int k = 0; k < NTAP; k++) begin
                w_reg[k] <= s_tdata[k*SAMPLE_W +: SAMPLE_W];
                d_reg[k] <= s_tdata[(NTAP+k)*SAMPLE_W +: SAMPLE_W];
            end
            frac_x_reg <= s_tdata[128 +: FRAC_IN_W];
            frac_y_reg <= s_tdata[136 +: FRAC_IN_W];
        end
        if (col_wr) begin
            col_w_reg[column_count_reg] <= merge_w;
            col_d_reg[column_count_reg] <= merge_d;
        end
        if (x_done) begin
            wi_reg <= merge_w;
            di_reg <= merge_d;
        end
        if (out_load) begin
            m_tdata_reg <= {4'b0000, di_reg, wi_reg};
            m_tuser_reg <= keep_next;
        end
    end

    // keep test: signed weight compare, absolute distance in one extra bit
    assign di_ext    = (OUT_W + 1)'(di_reg);
    assign di_abs    = di_ext[OUT_W] ? -di_ext : di_ext;
    assign keep_next = (wi_reg > $signed({1'b0, threshold_reg}))
                    && (di_abs < $signed({2'b00, limit_reg}));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    // a result beat only appears from the output state
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && out_load) |-> (state_reg == ST_OUT && phase_x_reg))
        else $error("result loaded outside the x stage");

    // the fourth column hands over to the x cubic
    a_fourth_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && !phase_x_reg && column_count_reg == COL_LAST)
        |=> (phase_x_reg && state_reg == ST_FRAC && column_count_reg == '0))
        else $error("fourth column did not start the x cubic");

    // no new column beat while the x cubic is running
    a_no_accept_in_x: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_x_reg |-> !s_tready)
        else $error("input ready during x stage");

    // the column counter moves only on a column write
    a_count_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && column_count_reg != $past(column_count_reg))
        |-> $past(state_reg == ST_SUM && !phase_x_reg))
        else $error("column count changed without a column write");
`endif

endmodule

>>> verif/bsf_point_checker.sv
// ----------------------------------------------------------------------------
// bsf_point_checker - scoreboard for the bicubic sdf point filter
// watches the column, result and register channels, predicts each point's
// interpolated weight, distance and keep flag, and compares result beats
// ----------------------------------------------------------------------------
module bsf_point_checker import bsf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [143:0]     s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [39:0]      m_tdata,
    input  logic             m_tuser,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               points_pending,
    output int               results_seen,
    output int               kept_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_REPORTS = 10;
    localparam longint SAT_HI      = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint SAT_LO      = -(longint'(1) << (OUT_W - 1));

    typedef struct packed {
        logic signed [OUT_W-1:0] weight;
        logic signed [OUT_W-1:0] distance;
        logic                    keep;
    } point_verdict_t;

    point_verdict_t          expected_points [$];
    logic [CFG_W-1:0]        weight_threshold;
    logic [CFG_W-1:0]        distance_limit;
    logic [COL_W-1:0]        next_col;
    logic signed [OUT_W-1:0] col_weight [NTAP];
    logic signed [OUT_W-1:0] col_dist   [NTAP];

    // floor((v + half) / 2^sh)
    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    // catmull-rom taps for one fraction, exact in Q(3F+1), then moved to Q16
    function automatic void catmull_rom_taps(input logic [FRAC_IN_W-1:0] frac,
                                             output longint taps [NTAP]);
        longint s, f, f2, f3, s2, s3;
        longint raw [NTAP];
        int     sh;
        s  = longint'(1) << FRAC_BITS;
        f  = longint'(frac) & (s - 1);
        f2 = f * f;
        f3 = f2 * f;
        s2 = s * s;
        s3 = s2 * s;
        raw[0] = -f3 + 2 * f2 * s - f * s2;
        raw[1] = 3 * f3 - 5 * f2 * s + 2 * s3;
        raw[2] = -3 * f3 + 4 * f2 * s + f * s2;
        raw[3] = f3 - f2 * s;
        sh = 3 * FRAC_BITS + 1 - BASIS_BITS;
        for (int k = 0; k < NTAP; k++)
            taps[k] = (sh > 0) ? round_half_up(raw[k], sh) : (raw[k] << (-sh));
    endfunction

    function automatic logic signed [OUT_W-1:0] cubic_sat(input longint taps [NTAP],
                                                          input longint v [NTAP]);
        longint acc, r;
        acc = 0;
        for (int k = 0; k < NTAP; k++)
            acc += taps[k] * v[k];
        r = round_half_up(acc, BASIS_BITS);
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        return OUT_W'(r);
    endfunction

    // reduce one column in y; the fourth column closes the point in x
    function automatic void take_column(input logic [143:0] beat);
        longint         ty [NTAP];
        longint         tx [NTAP];
        longint         wv [NTAP];
        longint         dv [NTAP];
        longint         mag;
        point_verdict_t v;
        catmull_rom_taps(beat[143:136], ty);
        for (int k = 0; k < NTAP; k++) begin
            wv[k] = longint'(beat[16*k +: 16]);
            dv[k] = longint'($signed(beat[64+16*k +: 16]));
        end
        col_weight[next_col] = cubic_sat(ty, wv);
        col_dist[next_col]   = cubic_sat(ty, dv);
        if (next_col == COL_LAST) begin
            catmull_rom_taps(beat[135:128], tx);
            for (int k = 0; k < NTAP; k++) begin
                wv[k] = longint'(col_weight[k]);
                dv[k] = longint'(col_dist[k]);
            end
            v.weight   = cubic_sat(tx, wv);
            v.distance = cubic_sat(tx, dv);
            mag        = (v.distance < 0) ? -longint'(v.distance) : longint'(v.distance);
            // signed compare: a negative weight never passes
            v.keep     = (longint'(v.weight) > longint'(weight_threshold)) &&
                         (mag < longint'(distance_limit));
            expected_points.insert(expected_points.size(), v);
        end
        next_col = next_col + 1'b1;
    endfunction

    function automatic void flag_point(input string what, input point_verdict_t want,
                                       input point_verdict_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display({"%0t %s: expected weight %0d dist %0d keep %0b, ",
                      "got weight %0d dist %0d keep %0b"},
                     $time, what, want.weight, want.distance, want.keep,
                     got.weight, got.distance, got.keep);
    endfunction

    function automatic void check_result(input logic [39:0] data, input logic keep_bit);
        point_verdict_t got, want;
        got.weight   = data[OUT_W-1:0];
        got.distance = data[2*OUT_W-1:OUT_W];
        got.keep     = keep_bit;
        results_seen++;
        if (keep_bit) kept_seen++;
        if (expected_points.size() == 0) begin
            flag_point("result beat with no point pending", '0, got);
        end else begin
            want = expected_points.pop_front();
            if (got.weight !== want.weight || got.distance !== want.distance ||
                got.keep !== want.keep)
                flag_point("result mismatch", want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            weight_threshold = THRESHOLD_RST;
            distance_limit   = DIST_LIMIT_RST;
            next_col         = '0;
            expected_points.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_WEIGHT_THRESHOLD: weight_threshold = cfg_data;
                    CFG_DISTANCE_LIMIT:   distance_limit   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_column(s_tdata);
        end
        points_pending = expected_points.size();
    end

endmodule

>>> verif/bicubic_sdf_point_filter_tb.sv
// ----------------------------------------------------------------------------
// bicubic_sdf_point_filter_tb - stimulus and verdict for the point filter
// drives column beats and register writes, stalls the result side, and lets
// the checker beside the block predict and compare every result beat
// ----------------------------------------------------------------------------
module bicubic_sdf_point_filter_tb import bsf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 40;    // a full point: three short columns plus the long one
    localparam int LONG_STALL    = 400;   // result side held off, enough to back up the input
    localparam int QUIET_LIMIT   = 5000;  // cycles without any beat before giving up

    // kinds of random points
    typedef enum int {
        PT_SURFACE,   // heavy weights, distances mostly near zero: keep decided by the limits
        PT_NOISE,     // every field fully random
        PT_FLAT       // each column constant over its rows
    } point_style_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    // weight_y0..3, dist_y0..3, frac_x, frac_y from bit 0 up
    logic [143:0]     s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    // weight_interp, dist_interp, zero fill
    logic [39:0]      m_tdata;
    // keep
    logic             m_tuser;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int fail_count;
    int points_pending;
    int results_seen;
    int kept_seen;

    int src_idle_pct  = 10;
    int sink_idle_pct = 73;
    bit stall_go      = 1'b0;
    int columns_sent  = 0;
    int settings_used = 1;   // reset values count as the first
    int quiet_cycles  = 0;

    bicubic_sdf_point_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bsf_point_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .points_pending (points_pending),
        .results_seen   (results_seen),
        .kept_seen      (kept_seen)
    );

    // clock
    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // result side: random back-pressure, or one long hold-off when asked
    initial begin : result_sink
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_go) begin
                stall_go = 1'b0;
                for (n = 0; n < LONG_STALL; n++) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // watchdog: any beat on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no beat moved for %0d cycles, %0d points still pending",
                 QUIET_LIMIT, points_pending);
        $display("Test completed with failures");
        $finish;
    end

    // one column beat; the valid stays up afterwards unless the next call idles
    task automatic send_column(input logic [143:0] beat);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        columns_sent++;
    endtask

    // the same column four times over
    task automatic send_same_columns(input logic [143:0] beat);
        repeat (NTAP) send_column(beat);
    endtask

    function automatic logic [143:0] random_column(input point_style_t style, input int span);
        logic [143:0] beat;
        logic [15:0]  w, d;
        w = 16'($urandom);
        d = 16'($urandom);
        for (int k = 0; k < NTAP; k++) begin
            case (style)
                PT_SURFACE: begin
                    beat[16*k +: 16]    = 16'($urandom_range(65535, 45000));
                    beat[64+16*k +: 16] = 16'(int'($urandom_range(2 * span)) - span);
                end
                PT_FLAT: begin
                    beat[16*k +: 16]    = w;
                    beat[64+16*k +: 16] = d;
                end
                default: begin
                    beat[16*k +: 16]    = 16'($urandom);
                    beat[64+16*k +: 16] = 16'($urandom);
                end
            endcase
        end
        beat[135:128] = 8'($urandom);
        beat[143:136] = 8'($urandom);
        return beat;
    endfunction

    task automatic run_random_points(input int count);
        point_style_t style;
        int           pick, span;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 60)
                style = PT_SURFACE;
            else if (pick < 85)
                style = PT_NOISE;
            else
                style = PT_FLAT;
            // mostly tight distances, now and then the whole range
            span  = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(48);
            repeat (NTAP) send_column(random_column(style, span));
        end
    endtask

    // stop offering, wait for every pending point, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (points_pending == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // only called with the block drained
    task automatic write_config(input logic [CFG_W-1:0] threshold,
                                input logic [CFG_W-1:0] limit);
        put_reg(CFG_WEIGHT_THRESHOLD, threshold);
        put_reg(CFG_DISTANCE_LIMIT, limit);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WEIGHT_THRESHOLD;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed points under the reset settings (threshold 0, limit 13)
        // zero weight is not strictly above a zero threshold
        send_same_columns({8'd0, 8'd0, {4{16'h0000}}, {4{16'h0000}}});
        // full-scale weight, zero distance, fractions at their top
        send_same_columns({8'd255, 8'd255, {4{16'h0000}}, {4{16'hFFFF}}});
        // negative distance just inside the limit is kept
        send_same_columns({8'd128, 8'd128, {4{16'hFFF4}}, {4{16'hFFFF}}});
        // distance equal to the limit is dropped
        send_same_columns({8'd254, 8'd1, {4{16'h000D}}, {4{16'hFFFF}}});
        // most negative distance, alternating fraction bits
        send_same_columns({8'h55, 8'hAA, {4{16'h8000}}, {4{16'h1234}}});
        // ringing: inner rows low, outer rows high drives the weight negative,
        // never kept; distances swing to both rails and overshoot 16 bits
        send_same_columns({8'd128, 8'd128,
                           16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                           16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
        drain();

        // sender mostly busy, receiver mostly stalling
        write_config(CFG_W'(62258), CFG_W'(13));
        run_random_points(70);
        drain();

        // roles swapped: sender sparse, receiver nearly always ready
        src_idle_pct  = 73;
        sink_idle_pct = 10;
        write_config('0, '1);
        run_random_points(70);
        drain();
        write_config('1, '0);
        run_random_points(30);
        drain();

        // no idling at all; one long result stall, then a full drain mid-phase
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_config(CFG_W'($urandom_range(65535, 40000)), CFG_W'($urandom_range(300)));
        run_random_points(10);
        stall_go = 1'b1;
        run_random_points(30);
        drain();
        run_random_points(20);
        drain();

        write_config(CFG_W'($urandom), CFG_W'($urandom));
        run_random_points(64);
        drain();

        $display("covered %0d column beats, %0d points checked (%0d kept)",
                 columns_sent, results_seen, kept_seen);
        $display("over %0d register settings, both idling patterns, a %0d-cycle result stall",
                 settings_used, LONG_STALL);
        $display("and mid-run drains");
        if (fail_count == 0 && points_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
